[hdl/avf_pkg.sv]
// ----------------------------------------------------------------------------
// avf_pkg
// Shared types, widths and reset values of the altitude/velocity fusion block.
// ----------------------------------------------------------------------------
package avf_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 31;

    localparam int unsigned MulAW    = 35;
    localparam int unsigned MulBW    = 20;
    localparam int unsigned ProdW    = MulAW + MulBW;

    localparam logic [16:0] BlendRst    = 17'd65339;
    localparam logic [18:0] GainRst     = 19'd65536;
    localparam logic [30:0] DeadbandRst = 31'd2621;
    localparam logic [16:0] LeakRst     = 17'd65208;

    // input beat kinds
    localparam logic ActAccel    = 1'b0;
    localparam logic ActAltitude = 1'b1;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BLEND    = 3'd0,
        CFG_GAIN     = 3'd1,
        CFG_DEADBAND = 3'd2,
        CFG_LEAK     = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [16:0] altitude_blend;
        logic [18:0] velocity_gain;
        logic [30:0] accel_deadband;
        logic [16:0] velocity_leak;
    } t_cfg;

endpackage

[hdl/avf_if.sv]
// ----------------------------------------------------------------------------
// avf_in_if / avf_out_if
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
interface avf_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] sample_value;
    logic        [15:0] time_step;

    modport source (output valid, action, sample_value, time_step, input ready);
    modport sink   (input valid, action, sample_value, time_step, output ready);
endinterface

interface avf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fused_alt;
    logic signed [31:0] vertical_speed;

    modport source (output valid, fused_alt, vertical_speed, input ready);
    modport sink   (input valid, fused_alt, vertical_speed, output ready);
endinterface

[hdl/avf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// avf_cfg_regs
// Configuration register file: indexed writes, out-of-range indexes dropped.
// ----------------------------------------------------------------------------
module avf_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [avf_pkg::CfgIdxW-1:0]       i_index,
    input  logic [avf_pkg::CfgDataW-1:0]      i_data,
    output avf_pkg::t_cfg                     o_cfg
);

    avf_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.altitude_blend <= avf_pkg::BlendRst;
            r_cfg.velocity_gain  <= avf_pkg::GainRst;
            r_cfg.accel_deadband <= avf_pkg::DeadbandRst;
            r_cfg.velocity_leak  <= avf_pkg::LeakRst;
        end else if (i_wr_en) begin
            case (i_index)
                avf_pkg::CFG_BLEND:    r_cfg.altitude_blend <= i_data[16:0];
                avf_pkg::CFG_GAIN:     r_cfg.velocity_gain  <= i_data[18:0];
                avf_pkg::CFG_DEADBAND: r_cfg.accel_deadband <= i_data[30:0];
                avf_pkg::CFG_LEAK:     r_cfg.velocity_leak  <= i_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/avf_mul.sv]
// ----------------------------------------------------------------------------
// avf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module avf_mul (
    input  logic                                 i_clk,
    input  logic signed [avf_pkg::MulAW-1:0]     i_a,
    input  logic signed [avf_pkg::MulBW-1:0]     i_b,
    output logic signed [avf_pkg::ProdW-1:0]     o_prod
);

    logic signed [avf_pkg::ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[hdl/avf_core.sv]
// ----------------------------------------------------------------------------
// avf_core
// Sequencer and state of the filter; drives the shared multiplier.
// ----------------------------------------------------------------------------
module avf_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  avf_pkg::t_cfg                        i_cfg,
    avf_in_if.sink                               i_sample,
    avf_out_if.source                            o_result,
    output logic signed [avf_pkg::MulAW-1:0]     o_mul_a,
    output logic signed [avf_pkg::MulBW-1:0]     o_mul_b,
    input  logic signed [avf_pkg::ProdW-1:0]     i_prod
);

    typedef enum logic [3:0] {
        S_IDLE, S_A_DB, S_A_M1, S_A_V1, S_A_M2, S_A_V2,
        S_B_M1, S_B_M2, S_B_F, S_B_T, S_B_M4, S_B_Z, S_DONE
    } t_state;

    // round to nearest, ties away from zero, drop 16 fraction bits
    function automatic logic signed [40:0] qround(input logic signed [55:0] x);
        logic [55:0] mag;
        logic [55:0] sum;
        logic [40:0] r;
        mag = x[55] ? 56'(-x) : 56'(x);
        sum = mag + 56'd32768;
        r   = {1'b0, sum[55:16]};
        return x[55] ? 41'(-r) : r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        if (x > 42'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -42'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    t_state                   r_state;
    logic                     r_act;
    logic signed [31:0]       r_smp;
    logic        [15:0]       r_dt;
    logic signed [34:0]       r_opnd;
    logic signed [54:0]       r_acc;
    logic signed [31:0]       r_filt;
    logic signed [34:0]       r_t;
    logic signed [31:0]       r_alt;
    logic signed [31:0]       r_vel;
    logic                     r_out_valid;
    logic signed [31:0]       r_out_alt;
    logic signed [31:0]       r_out_vel;

    logic signed [32:0]       w_mag;
    logic signed [32:0]       w_th;
    logic signed [34:0]       w_shrunk;
    logic        [16:0]       w_blend;
    logic        [16:0]       w_blend_c;
    logic signed [40:0]       w_q_prod;
    logic signed [40:0]       w_q_sum;
    logic signed [41:0]       w_v_sum;
    logic signed [41:0]       w_z_sum;
    logic                     w_accept;

    assign w_accept = i_sample.valid && i_sample.ready;

    // deadband: shrink toward zero, zero inside the band
    assign w_mag = r_smp[31] ? -{r_smp[31], r_smp} : {r_smp[31], r_smp};
    assign w_th  = {2'b00, i_cfg.accel_deadband};
    always_comb begin
        if (w_mag < w_th) begin
            w_shrunk = '0;
        end else if (!r_smp[31]) begin
            w_shrunk = 35'(r_smp) - 35'(w_th);
        end else begin
            w_shrunk = 35'(r_smp) + 35'(w_th);
        end
    end

    assign w_blend   = i_cfg.altitude_blend[16] ? 17'h10000 : i_cfg.altitude_blend;
    assign w_blend_c = 17'h10000 - w_blend;

    assign w_q_prod = qround(56'(i_prod));
    assign w_q_sum  = qround(56'(r_acc) + 56'(i_prod));
    assign w_v_sum  = 42'(r_vel) + 42'(w_q_prod);
    assign w_z_sum  = 42'(r_filt) + 42'(w_q_prod);

    // multiplier operand select
    always_comb begin
        o_mul_a = '0;
        o_mul_b = '0;
        case (r_state)
            S_A_M1: begin
                o_mul_a = r_opnd;
                o_mul_b = 20'({4'b0, r_dt});
            end
            S_A_M2: begin
                o_mul_a = 35'(r_vel);
                o_mul_b = 20'({3'b0, i_cfg.velocity_leak});
            end
            S_B_M1: begin
                if (r_alt == '0) begin
                    o_mul_a = 35'(r_vel);
                    o_mul_b = 20'({1'b0, i_cfg.velocity_gain});
                end else begin
                    o_mul_a = 35'(r_alt);
                    o_mul_b = 20'({3'b0, w_blend});
                end
            end
            S_B_M2: begin
                o_mul_a = 35'(r_smp);
                o_mul_b = 20'({3'b0, w_blend_c});
            end
            S_B_F: begin
                o_mul_a = 35'(r_vel);
                o_mul_b = 20'({1'b0, i_cfg.velocity_gain});
            end
            S_B_M4: begin
                o_mul_a = r_t;
                o_mul_b = 20'({4'b0, r_dt});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alt       <= '0;
            r_vel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the done step reloads the output register itself
            if (r_out_valid && o_result.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_act   <= i_sample.action;
                        r_smp   <= i_sample.sample_value;
                        r_dt    <= i_sample.time_step;
                        r_state <= (i_sample.action == avf_pkg::ActAltitude) ?
                                   S_B_M1 : S_A_DB;
                    end
                end
                S_A_DB: begin
                    r_opnd  <= w_shrunk;
                    r_state <= S_A_M1;
                end
                S_A_M1: r_state <= S_A_V1;
                S_A_V1: begin
                    r_vel   <= sat32(w_v_sum);
                    r_state <= S_A_M2;
                end
                S_A_M2: r_state <= S_A_V2;
                S_A_V2: begin
                    r_vel   <= sat32(42'(w_q_prod));
                    r_state <= S_DONE;
                end
                S_B_M1: begin
                    // load the reading directly while the stored altitude is zero
                    if (r_alt == '0) begin
                        r_filt  <= r_smp;
                        r_state <= S_B_T;
                    end else begin
                        r_state <= S_B_M2;
                    end
                end
                S_B_M2: begin
                    r_acc   <= i_prod;
                    r_state <= S_B_F;
                end
                S_B_F: begin
                    r_filt  <= w_q_sum[31:0];
                    r_state <= S_B_T;
                end
                S_B_T: begin
                    r_t     <= w_q_prod[34:0];
                    r_state <= S_B_M4;
                end
                S_B_M4: r_state <= S_B_Z;
                S_B_Z: begin
                    r_alt   <= sat32(w_z_sum);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_alt   <= r_alt;
                        r_out_vel   <= r_vel;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_sample.ready          = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.fused_alt      = r_out_alt;
    assign o_result.vertical_speed = r_out_vel;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result beat raised outside the done step");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("sequencer did not start on an accepted beat");

    a_alt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_B_Z) |=> $stable(r_alt))
        else $error("altitude changed outside its update step");

    a_vel_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_A_V1 && r_state != S_A_V2) |=> $stable(r_vel))
        else $error("velocity changed outside its update steps");

    a_path_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_B_Z || r_state == S_B_T) |-> (r_act == avf_pkg::ActAltitude))
        else $error("altitude step entered for an acceleration beat");

endmodule

[hdl/altitude_velocity_fusion.sv]
// ----------------------------------------------------------------------------
// altitude_velocity_fusion
// Complementary-filter altitude estimator, barometer plus vertical accel.
// ----------------------------------------------------------------------------
// i_sample carries one beat per sensor reading: action 0 is an acceleration
// sample, action 1 a barometric altitude; time_step is Q0.16 s. o_result
// returns one beat per sample with the fused altitude and the vertical speed
// after that sample, both signed Q16.16. Configuration is written through
// i_cfg_wr_en / i_cfg_index / i_cfg_data; the user must write it only while
// no sample is in flight, which the block does not enforce; unknown indexes
// are dropped. One multiplier with a registered product serves all steps.
// An acceleration sample is deadbanded, multiplied by time_step and added
// to the velocity, which is then scaled by the leak; an altitude sample is
// blended with the stored altitude, or loaded while that is zero, and gets
// gain * velocity * time_step added. i_sample.ready is high only while idle.
// Reset (synchronous, active low) clears altitude and velocity to zero and
// loads the default configuration. A result not taken waits in the output
// register; the next one holds in the sequencer and no beat is accepted.
// ----------------------------------------------------------------------------
module altitude_velocity_fusion (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    avf_in_if.sink                            i_sample,
    avf_out_if.source                         o_result,
    input  logic                              i_cfg_wr_en,
    input  logic [avf_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [avf_pkg::CfgDataW-1:0]      i_cfg_data
);

    avf_pkg::t_cfg                         w_cfg;
    logic signed [avf_pkg::MulAW-1:0]      w_mul_a;
    logic signed [avf_pkg::MulBW-1:0]      w_mul_b;
    logic signed [avf_pkg::ProdW-1:0]      w_prod;

    avf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    avf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    avf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_sample (i_sample),
        .o_result (o_result),
        .o_mul_a  (w_mul_a),
        .o_mul_b  (w_mul_b),
        .i_prod   (w_prod)
    );

endmodule

[tb/sv/altitude_velocity_fusion_tb.sv]
// ----------------------------------------------------------------------------
// altitude_velocity_fusion_tb
// Self-checking bench for the barometer/accelerometer altitude fusion block.
// A queue of sensor beats feeds a valid/ready driver. Each accepted beat runs
// through a local fixed-point estimator, and the monitor compares every result
// beat with the oldest estimate. Phases step through register settings,
// including the extremes, and through source idling and sink stalls.
// ----------------------------------------------------------------------------
module altitude_velocity_fusion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   QOne        = 65536;
    localparam int   SettleCycles = 12;
    localparam int   HoldOffCycles = 400;
    localparam longint CycleLimit = 1000000;
    localparam logic [avf_pkg::CfgIdxW-1:0] CfgIdxSpare = 3'd6;

    typedef struct packed {
        logic               action;
        logic signed [31:0] sample_value;
        logic        [15:0] time_step;
    } t_sensor_beat;

    typedef struct packed {
        logic signed [31:0] altitude;
        logic signed [31:0] speed;
    } t_fused_out;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_wr_en;
    logic [avf_pkg::CfgIdxW-1:0]   cfg_index;
    logic [avf_pkg::CfgDataW-1:0]  cfg_data;

    avf_in_if  sample_if ();
    avf_out_if result_if ();

    altitude_velocity_fusion DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // shadow of the block's registers and estimator state
    logic [16:0] blend_reg;
    logic [18:0] gain_reg;
    logic [30:0] deadband_reg;
    logic [16:0] leak_reg;
    int          est_altitude;
    int          est_speed;

    t_sensor_beat sensor_beat_q[$];
    t_fused_out   fused_expect_q[$];

    int     src_idle_pct;
    int     sink_stall_pct;
    int     pressure_req;
    int     hold_seen;
    int     hold_left;
    int     mismatches;
    longint cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 rescale, round to nearest with ties away from zero
    function automatic longint rnd16(longint x);
        if (x >= 0)
            return (x + 32768) >>> 16;
        return -(((-x) + 32768) >>> 16);
    endfunction

    function automatic t_fused_out fuse_step(t_sensor_beat b);
        longint s, dt, v, z, th, mag, d, a, filt, t;
        t_fused_out r;
        s  = longint'($signed(b.sample_value));
        dt = longint'(b.time_step);
        v  = longint'(est_speed);
        z  = longint'(est_altitude);
        if (b.action == avf_pkg::ActAccel) begin
            th  = longint'(deadband_reg);
            mag = (s < 0) ? -s : s;
            if (mag < th)
                d = 0;
            else
                d = (s > 0) ? s - th : s + th;
            v = sat32(v + rnd16(d * dt));
            v = sat32(rnd16(v * longint'(leak_reg)));
            est_speed = int'(v);
        end else begin
            a = longint'(blend_reg);
            if (a > QOne)
                a = QOne;
            // a stored altitude of exactly zero means "not yet seeded": load
            if (z == 0)
                filt = s;
            else
                filt = rnd16(a * z + (QOne - a) * s);
            t = rnd16(longint'(gain_reg) * v);
            t = rnd16(t * dt);
            est_altitude = int'(sat32(filt + t));
        end
        r.altitude = est_altitude;
        r.speed    = est_speed;
        return r;
    endfunction

    function automatic t_sensor_beat rand_beat();
        t_sensor_beat b;
        longint edge_val;
        b.action = ($urandom_range(1) != 0) ? avf_pkg::ActAltitude : avf_pkg::ActAccel;
        case ($urandom_range(9))
            0, 1, 2: b.sample_value = $urandom;
            3, 4, 5: b.sample_value = int'($urandom_range(40 * QOne)) - 20 * QOne;
            6, 7:    b.sample_value = int'($urandom_range(2000 * QOne)) - 100 * QOne;
            8: begin
                case ($urandom_range(2))
                    0:       b.sample_value = 32'sh7FFF_FFFF;
                    1:       b.sample_value = 32'sh8000_0000;
                    default: b.sample_value = '0;
                endcase
            end
            default: begin
                // straddle the deadband threshold
                edge_val = longint'(deadband_reg) + longint'($urandom_range(2)) - 1;
                if ($urandom_range(1) != 0)
                    edge_val = -edge_val;
                b.sample_value = edge_val[31:0];
            end
        endcase
        case ($urandom_range(7))
            0:       b.time_step = '0;
            1:       b.time_step = 16'hFFFF;
            2, 3:    b.time_step = 16'($urandom_range(65535));
            default: b.time_step = 16'($urandom_range(2000, 1));
        endcase
        return b;
    endfunction

    // sample source: hold the beat until taken, predict on the accepting edge
    always @(posedge i_clk) begin : sample_driver
        t_sensor_beat taken;
        t_sensor_beat nxt;
        if (!i_rst_n) begin
            sample_if.valid        <= 1'b0;
            sample_if.action       <= avf_pkg::ActAccel;
            sample_if.sample_value <= '0;
            sample_if.time_step    <= '0;
        end else begin
            if (sample_if.valid && sample_if.ready) begin
                taken.action       = sample_if.action;
                taken.sample_value = sample_if.sample_value;
                taken.time_step    = sample_if.time_step;
                fused_expect_q.push_back(fuse_step(taken));
            end
            if (!sample_if.valid || sample_if.ready) begin
                if (sensor_beat_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt = sensor_beat_q.pop_front();
                    sample_if.valid        <= 1'b1;
                    sample_if.action       <= nxt.action;
                    sample_if.sample_value <= nxt.sample_value;
                    sample_if.time_step    <= nxt.time_step;
                end else begin
                    sample_if.valid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off, restarted on every pressure request
    always @(posedge i_clk) begin : sink_hold_off
        if (!i_rst_n) begin
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_seen != pressure_req) begin
            hold_seen <= pressure_req;
            hold_left <= HoldOffCycles;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result sink: compare each beat against the oldest estimate
    always @(posedge i_clk) begin : result_monitor
        t_fused_out want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                if (fused_expect_q.size() == 0) begin
                    $display("%0t ERROR: unexpected result: expected none, actual alt %0d speed %0d",
                             $time, result_if.fused_alt, result_if.vertical_speed);
                    mismatches++;
                end else begin
                    want = fused_expect_q.pop_front();
                    if (result_if.fused_alt !== want.altitude) begin
                        $display("%0t ERROR: fused_alt expected %0d actual %0d",
                                 $time, want.altitude, result_if.fused_alt);
                        mismatches++;
                    end
                    if (result_if.vertical_speed !== want.speed) begin
                        $display("%0t ERROR: vertical_speed expected %0d actual %0d",
                                 $time, want.speed, result_if.vertical_speed);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("altitude_velocity_fusion_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [avf_pkg::CfgIdxW-1:0] idx,
                             input logic [avf_pkg::CfgDataW-1:0] data);
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            avf_pkg::CFG_BLEND:    blend_reg    = data[16:0];
            avf_pkg::CFG_GAIN:     gain_reg     = data[18:0];
            avf_pkg::CFG_DEADBAND: deadband_reg = data[30:0];
            avf_pkg::CFG_LEAK:     leak_reg     = data[16:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input int unsigned blend, input int unsigned gain,
                              input int unsigned deadband, input int unsigned leak);
        write_reg(avf_pkg::CFG_BLEND, blend[avf_pkg::CfgDataW-1:0]);
        write_reg(avf_pkg::CFG_GAIN, gain[avf_pkg::CfgDataW-1:0]);
        write_reg(avf_pkg::CFG_DEADBAND, deadband[avf_pkg::CfgDataW-1:0]);
        write_reg(avf_pkg::CFG_LEAK, leak[avf_pkg::CfgDataW-1:0]);
    endtask

    task automatic push_beat(input logic action, input int sample, input int unsigned dt);
        t_sensor_beat b;
        b.action       = action;
        b.sample_value = sample;
        b.time_step    = dt[15:0];
        sensor_beat_q.push_back(b);
    endtask

    // drain everything, then give the sequencer time to go idle
    task automatic drain();
        @(negedge i_clk);
        while (sensor_beat_q.size() != 0 || sample_if.valid || fused_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic run_random(input int n, input int src_pct, input int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n) sensor_beat_q.push_back(rand_beat());
        drain();
    endtask

    initial begin
        int db;
        i_rst_n      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_if.valid        = 1'b0;
        sample_if.action       = avf_pkg::ActAccel;
        sample_if.sample_value = '0;
        sample_if.time_step    = '0;
        result_if.ready        = 1'b0;
        blend_reg    = avf_pkg::BlendRst;
        gain_reg     = avf_pkg::GainRst;
        deadband_reg = avf_pkg::DeadbandRst;
        leak_reg     = avf_pkg::LeakRst;
        est_altitude = 0;
        est_speed    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        pressure_req   = 0;
        mismatches     = 0;
        cycle_count    = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: seeding, deadband edges, field extremes, saturation
        db = int'(avf_pkg::DeadbandRst);
        push_beat(avf_pkg::ActAltitude, 0, 0);
        push_beat(avf_pkg::ActAltitude, 100 * QOne, 1000);
        push_beat(avf_pkg::ActAltitude, 101 * QOne, 65535);
        push_beat(avf_pkg::ActAccel, 32'sh7FFF_FFFF, 65535);
        push_beat(avf_pkg::ActAccel, 32'sh8000_0000, 65535);
        push_beat(avf_pkg::ActAccel, db - 1, 65535);
        push_beat(avf_pkg::ActAccel, -(db - 1), 65535);
        push_beat(avf_pkg::ActAccel, db, 65535);
        push_beat(avf_pkg::ActAccel, -db - 1, 65535);
        repeat (3) push_beat(avf_pkg::ActAccel, 642253, 655);
        push_beat(avf_pkg::ActAltitude, 32'sh7FFF_FFFF, 65535);
        push_beat(avf_pkg::ActAltitude, 32'sh8000_0000, 65535);
        push_beat(avf_pkg::ActAltitude, -100 * QOne, 0);
        repeat (4) push_beat(avf_pkg::ActAccel, 32'sh7FFF_FFFF, 65535);
        push_beat(avf_pkg::ActAltitude, 32'sh7FFF_FFFF, 65535);
        repeat (6) push_beat(avf_pkg::ActAccel, 32'sh8000_0000, 65535);
        push_beat(avf_pkg::ActAltitude, 32'sh8000_0000, 65535);
        drain();

        // extremes: no blending memory, no velocity term, no deadband, unity leak
        set_config(0, 0, 0, QOne);
        pressure_req++;
        run_random(200, 0, 0);

        set_config(QOne, 262144, 31'h7FFF_FFFF, 0);
        run_random(150, 76, 0);

        // weights above one: blend clamps, leak saturates
        set_config(17'h1FFFF, 19'h7FFFF, 300, 17'h1FFFF);
        run_random(200, 0, 76);

        // a write to an unused index must leave the registers alone
        write_reg(CfgIdxSpare, 31'h7FFF_FFFF);
        set_config(avf_pkg::BlendRst, avf_pkg::GainRst, avf_pkg::DeadbandRst,
                   avf_pkg::LeakRst);
        write_reg(CfgIdxSpare, 31'h0000_0000);
        pressure_req++;
        run_random(250, 6, 6);

        for (int ph = 0; ph < 6; ph++) begin
            set_config(($urandom_range(7) == 0) ? $urandom_range(131071) : $urandom_range(QOne),
                       $urandom_range(262144),
                       ($urandom_range(3) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                                : $urandom_range(2 * QOne),
                       ($urandom_range(7) == 0) ? $urandom_range(131071)
                                                : $urandom_range(QOne, 60000));
            case (ph % 4)
                0: run_random(120, 0, 0);
                1: run_random(120, 76, 0);
                2: run_random(120, 0, 76);
                default: run_random(120, 6, 6);
            endcase
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && fused_expect_q.size() == 0) begin
            $display("altitude_velocity_fusion_tb: PASS");
        end else begin
            $display("altitude_velocity_fusion_tb: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/avf_pkg.sv
hdl/avf_if.sv
hdl/avf_cfg_regs.sv
hdl/avf_mul.sv
hdl/avf_core.sv
hdl/altitude_velocity_fusion.sv
tb/sv/altitude_velocity_fusion_tb.sv
